/* sv/lbs_pkg.sv */
// shared types and constants for the line-draw blitter step
package lbs_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 24;
   localparam int OUT_ADDR_BITS = 24;
   localparam int WORD_BITS = 16;
   localparam int SHIFT_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int BYTES_PER_WORD = 2;

   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = 4'd15;
   localparam logic [SHIFT_BITS-1:0] SHIFT_MIN = 4'd0;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONTROL        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_MOD          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_MOD          = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_MOD          = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECISION_START = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_START        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_D_START        = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_PATTERN   = 3'd7;

   // control register bit positions
   localparam int CTL_A_SHIFT_LSB = 28;
   localparam int CTL_USE_A       = 27;
   localparam int CTL_USE_B       = 26;
   localparam int CTL_USE_C       = 25;
   localparam int CTL_MINTERM_LSB = 16;
   localparam int CTL_B_SHIFT_LSB = 12;
   localparam int CTL_SIGN        = 6;
   localparam int CTL_SUD         = 4;
   localparam int CTL_SUL         = 3;
   localparam int CTL_AUL         = 2;
   localparam int CTL_SING        = 1;

   typedef struct packed {
      logic                      start_line;
      logic [WORD_BITS-1:0]      c_word;
      logic [WORD_BITS-1:0]      b_word;
      logic                      last_pixel;
   } req_type;

   typedef struct packed {
      logic                      write_enable;
      logic [OUT_ADDR_BITS-1:0]  write_address;
      logic [WORD_BITS-1:0]      write_data;
      logic [OUT_ADDR_BITS-1:0]  next_c_address;
      logic [OUT_ADDR_BITS-1:0]  decision_value;
      logic                      sign_out;
      logic [SHIFT_BITS-1:0]     a_shift_out;
      logic [SHIFT_BITS-1:0]     b_shift_out;
      logic                      zero_result;
      logic                      line_done;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0]  control;
      logic signed [15:0]        a_mod;
      logic signed [15:0]        b_mod;
      logic signed [15:0]        c_mod;
      logic [OUT_ADDR_BITS-1:0]  decision_start;
      logic [OUT_ADDR_BITS-1:0]  c_start;
      logic [OUT_ADDR_BITS-1:0]  d_start;
      logic [CSR_DATA_BITS-1:0]  line_pattern;
   } cfg_type;

endpackage

/* sv/lbs_csr.sv */
// configuration register file of the line-draw blitter step
module lbs_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [lbs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lbs_pkg::CSR_DATA_BITS-1:0]      csr_write_data,
   output lbs_pkg::cfg_type                       cfg
);

   lbs_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lbs_pkg::REG_CONTROL:        cfg_in.control = csr_write_data;
            lbs_pkg::REG_A_MOD:          cfg_in.a_mod = csr_write_data[15:0];
            lbs_pkg::REG_B_MOD:          cfg_in.b_mod = csr_write_data[15:0];
            lbs_pkg::REG_C_MOD:          cfg_in.c_mod = csr_write_data[15:0];
            lbs_pkg::REG_DECISION_START: begin
               cfg_in.decision_start = csr_write_data[lbs_pkg::OUT_ADDR_BITS-1:0];
            end
            lbs_pkg::REG_C_START: begin
               cfg_in.c_start = csr_write_data[lbs_pkg::OUT_ADDR_BITS-1:0];
            end
            lbs_pkg::REG_D_START: begin
               cfg_in.d_start = csr_write_data[lbs_pkg::OUT_ADDR_BITS-1:0];
            end
            lbs_pkg::REG_LINE_PATTERN:   cfg_in.line_pattern = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/lbs_core.sv */
// line state and single-pass pixel step: minterm, octant moves, decision update
module lbs_core #(
   parameter int ADDRESS_BITS = lbs_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lbs_pkg::req_type    item,
   input  lbs_pkg::cfg_type    cfg,
   output lbs_pkg::rsp_type    result
);

   localparam logic [ADDRESS_BITS-1:0] WORD_STEP = ADDRESS_BITS'(lbs_pkg::BYTES_PER_WORD);

   logic [ADDRESS_BITS-1:0]           c_ptr_ff, c_ptr_in;
   logic [ADDRESS_BITS-1:0]           d_ptr_ff, d_ptr_in;
   logic [ADDRESS_BITS-1:0]           decision_ff, decision_in;
   logic [lbs_pkg::SHIFT_BITS-1:0]    a_shift_ff, a_shift_in;
   logic [lbs_pkg::SHIFT_BITS-1:0]    b_shift_ff, b_shift_in;
   logic [lbs_pkg::WORD_BITS-1:0]     texture_ff, texture_in;
   logic                              sign_ff, sign_in;
   logic                              first_row_ff, first_row_in;
   logic                              all_zero_ff, all_zero_in;

   logic [ADDRESS_BITS-1:0]           c_ptr_cur, d_ptr_cur, decision_cur;
   logic [lbs_pkg::SHIFT_BITS-1:0]    a_shift_cur, b_shift_cur;
   logic [lbs_pkg::WORD_BITS-1:0]     texture_cur, a_word, data;
   logic                              sign_cur, first_row_cur, all_zero_cur;
   logic                              use_a, use_b, use_c, sud, sul, aul, sing;
   logic [7:0]                        minterm;
   logic                              b_bit;
   logic                              x_en, x_down, y_en, y_down, x_carry;
   logic [ADDRESS_BITS-1:0]           x_delta, y_delta, row_step, dec_inc;

   assign use_a   = cfg.control[lbs_pkg::CTL_USE_A];
   assign use_b   = cfg.control[lbs_pkg::CTL_USE_B];
   assign use_c   = cfg.control[lbs_pkg::CTL_USE_C];
   assign sud     = cfg.control[lbs_pkg::CTL_SUD];
   assign sul     = cfg.control[lbs_pkg::CTL_SUL];
   assign aul     = cfg.control[lbs_pkg::CTL_AUL];
   assign sing    = cfg.control[lbs_pkg::CTL_SING];
   assign minterm = cfg.control[lbs_pkg::CTL_MINTERM_LSB +: 8];

   // line start reloads state from the registers
   always_comb begin
      if (item.start_line) begin
         c_ptr_cur     = ADDRESS_BITS'(cfg.c_start);
         d_ptr_cur     = ADDRESS_BITS'(cfg.d_start);
         decision_cur  = ADDRESS_BITS'(cfg.decision_start);
         a_shift_cur   = cfg.control[lbs_pkg::CTL_A_SHIFT_LSB +: lbs_pkg::SHIFT_BITS];
         b_shift_cur   = cfg.control[lbs_pkg::CTL_B_SHIFT_LSB +: lbs_pkg::SHIFT_BITS];
         sign_cur      = cfg.control[lbs_pkg::CTL_SIGN];
         texture_cur   = cfg.line_pattern[lbs_pkg::WORD_BITS-1:0];
         first_row_cur = 1'b1;
         all_zero_cur  = 1'b1;
      end else begin
         c_ptr_cur     = c_ptr_ff;
         d_ptr_cur     = d_ptr_ff;
         decision_cur  = decision_ff;
         a_shift_cur   = a_shift_ff;
         b_shift_cur   = b_shift_ff;
         sign_cur      = sign_ff;
         texture_cur   = texture_ff;
         first_row_cur = first_row_ff;
         all_zero_cur  = all_zero_ff;
      end
   end

   assign texture_in = use_b ? item.b_word : texture_cur;
   assign a_word = cfg.line_pattern[lbs_pkg::CSR_DATA_BITS-1:lbs_pkg::WORD_BITS] >> a_shift_cur;
   assign b_bit = texture_in[b_shift_cur];
   assign b_shift_in = b_shift_cur - 1'b1;

   always_comb begin
      for (int i = 0; i < lbs_pkg::WORD_BITS; i++) begin
         data[i] = minterm[{a_word[i], b_bit, item.c_word[i]}];
      end
   end

   // octant: at most one horizontal and one vertical move per pixel
   assign x_en   = sud | ~sign_cur;
   assign x_down = sud ? aul : sul;
   assign y_en   = ~sud | ~sign_cur;
   assign y_down = sud ? sul : aul;

   assign x_carry  = x_down ? (a_shift_cur == lbs_pkg::SHIFT_MIN)
                            : (a_shift_cur == lbs_pkg::SHIFT_MAX);
   assign row_step = ADDRESS_BITS'(cfg.c_mod);

   always_comb begin
      a_shift_in = a_shift_cur;
      x_delta    = '0;
      if (x_en) begin
         a_shift_in = x_down ? a_shift_cur - 1'b1 : a_shift_cur + 1'b1;
         if (x_carry) begin
            x_delta = x_down ? -WORD_STEP : WORD_STEP;
         end
      end
      y_delta = '0;
      if (y_en) begin
         y_delta = y_down ? -row_step : row_step;
      end
   end

   assign c_ptr_in     = c_ptr_cur + x_delta + y_delta;
   assign d_ptr_in     = c_ptr_in;
   assign first_row_in = y_en;

   assign dec_inc     = sign_cur ? ADDRESS_BITS'(cfg.b_mod) : ADDRESS_BITS'(cfg.a_mod);
   assign decision_in = use_a ? decision_cur + dec_inc : decision_cur;
   assign sign_in     = decision_in[15];
   assign all_zero_in = all_zero_cur & (data == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ptr_ff     <= '0;
         d_ptr_ff     <= '0;
         decision_ff  <= '0;
         a_shift_ff   <= '0;
         b_shift_ff   <= '0;
         texture_ff   <= '0;
         sign_ff      <= 1'b0;
         first_row_ff <= 1'b1;
         all_zero_ff  <= 1'b1;
      end else if (step_en) begin
         c_ptr_ff     <= c_ptr_in;
         d_ptr_ff     <= d_ptr_in;
         decision_ff  <= decision_in;
         a_shift_ff   <= a_shift_in;
         b_shift_ff   <= b_shift_in;
         texture_ff   <= texture_in;
         sign_ff      <= sign_in;
         first_row_ff <= first_row_in;
         all_zero_ff  <= all_zero_in;
      end
   end

   always_comb begin
      result.write_enable   = (~sing | first_row_cur) & use_c;
      result.write_address  = lbs_pkg::OUT_ADDR_BITS'(d_ptr_cur);
      result.write_data     = data;
      result.next_c_address = lbs_pkg::OUT_ADDR_BITS'(c_ptr_in);
      result.decision_value = lbs_pkg::OUT_ADDR_BITS'(decision_in);
      result.sign_out       = sign_in;
      result.a_shift_out    = a_shift_in;
      result.b_shift_out    = b_shift_in;
      result.zero_result    = all_zero_in;
      result.line_done      = item.last_pixel;
   end

endmodule

/* sv/line_draw_blit_step.sv */
// Line-draw blitter step, one line pixel per transaction. A request is held in an input
// register, stepped against the line state by one pass of logic (minterm, octant
// moves of the C pointer, decision add) and the response lands in an output register.
// One pixel per cycle is sustained while rsp_ready keeps the output register draining, a rate
// set by the feedback of the pointer and decision adders into the line state registers.
// Requests keep flowing while a response waits, until both registers are full.
// A request with start_line reloads the line state from the registers first.
module line_draw_blit_step #(
   parameter int ADDRESS_BITS = lbs_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lbs_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lbs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [lbs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lbs_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   lbs_pkg::cfg_type cfg;
   lbs_pkg::req_type in_data_ff, in_data_in;
   lbs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   lbs_pkg::rsp_type step_result;
   logic             in_valid_ff, in_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance, req_take;

   lbs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lbs_core #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign in_data_in   = req_take ? req_data : in_data_ff;
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);
   assign rsp_data_in  = advance ? step_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a stepped pixel always shows up as a response
   a_step_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("stepped pixel produced no response");

   // an empty input register never back-pressures
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but request not ready");

   // a held request is neither lost nor altered
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held request lost or changed");

   // reported sign follows the decision word
   a_sign_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.sign_out == rsp_data_ff.decision_value[15]))
      else $error("sign does not match decision word");

endmodule
